FILE: hw/rtl/amr_pkg.sv
`timescale 1ns / 1ps

package amr_pkg;

  localparam int unsigned TUNE_LEN     = 14;
  localparam int unsigned EXTRA_NOTE_MS = 400;
  localparam int unsigned NOTE_NUM_W   = 6;
  localparam int unsigned TONE_W       = 10;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_HOUR   = 3'd0,
    CFG_ALARM_MINUTE = 3'd1,
    CFG_ALARM_ENABLE = 3'd2,
    CFG_BLINK_PERIOD = 3'd3,
    CFG_RING_TIMEOUT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_STOP = 1'b1
  } item_kind_e;

  localparam logic [4:0]  RST_ALARM_HOUR   = 5'd7;
  localparam logic [5:0]  RST_ALARM_MINUTE = 6'd0;
  localparam logic        RST_ALARM_ENABLE = 1'b0;
  localparam logic [15:0] RST_BLINK_PERIOD = 16'd500;
  localparam logic [31:0] RST_RING_TIMEOUT = 32'd60000;

  typedef struct packed {
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        alarm_enable;
    logic [15:0] blink_period_ms;
    logic [31:0] ring_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [5:0]  clock_minute;
    logic [4:0]  clock_hour;
    logic        kind;
  } item_t;

  typedef struct packed {
    logic                  redraw;
    logic                  just_fired;
    logic [NOTE_NUM_W-1:0] note_number;
    logic [TONE_W-1:0]     tone_hz;
    logic                  led_lit;
    logic                  ringing;
  } result_t;

  function automatic logic [TONE_W-1:0] tune_hz(input logic [NOTE_NUM_W-1:0] idx);
    logic [TONE_W-1:0] hz;
    case (idx)
      6'd0:    hz = 10'd659;
      6'd1:    hz = 10'd587;
      6'd2:    hz = 10'd370;
      6'd3:    hz = 10'd415;
      6'd4:    hz = 10'd554;
      6'd5:    hz = 10'd494;
      6'd6:    hz = 10'd294;
      6'd7:    hz = 10'd330;
      6'd8:    hz = 10'd494;
      6'd9:    hz = 10'd440;
      6'd10:   hz = 10'd277;
      6'd11:   hz = 10'd330;
      6'd12:   hz = 10'd440;
      default: hz = 10'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [9:0] tune_ms(input logic [NOTE_NUM_W-1:0] idx);
    logic [9:0] ms;
    case (idx)
      6'd0, 6'd1, 6'd4, 6'd5, 6'd8, 6'd9: ms = 10'd125;
      6'd2, 6'd3, 6'd6, 6'd7, 6'd10, 6'd11: ms = 10'd250;
      6'd12:   ms = 10'd500;
      default: ms = 10'(EXTRA_NOTE_MS);
    endcase
    return ms;
  endfunction

endpackage

FILE: hw/rtl/amr_cfg_regs.sv
`timescale 1ns / 1ps

module amr_cfg_regs
  import amr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_hour      <= RST_ALARM_HOUR;
      cfg_q.alarm_minute    <= RST_ALARM_MINUTE;
      cfg_q.alarm_enable    <= RST_ALARM_ENABLE;
      cfg_q.blink_period_ms <= RST_BLINK_PERIOD;
      cfg_q.ring_timeout_ms <= RST_RING_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALARM_HOUR:   cfg_q.alarm_hour      <= cfg_wdata_i[4:0];
        CFG_ALARM_MINUTE: cfg_q.alarm_minute    <= cfg_wdata_i[5:0];
        CFG_ALARM_ENABLE: cfg_q.alarm_enable    <= cfg_wdata_i[0];
        CFG_BLINK_PERIOD: cfg_q.blink_period_ms <= cfg_wdata_i[15:0];
        CFG_RING_TIMEOUT: cfg_q.ring_timeout_ms <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/amr_step.sv
`timescale 1ns / 1ps

module amr_step
  import amr_pkg::*;
#(
  parameter int unsigned MELODY_NOTES = 14,
  parameter int unsigned TIME_BITS    = 32,
  localparam int unsigned NOTE_W = (MELODY_NOTES > 1) ? $clog2(MELODY_NOTES) : 1
) (
  input  item_t                item_i,
  input  cfg_t                 cfg_i,
  input  logic                 ring_i,
  input  logic                 latch_i,
  input  logic                 led_i,
  input  logic [NOTE_W-1:0]    pos_i,
  input  logic [TIME_BITS-1:0] ring_start_i,
  input  logic [TIME_BITS-1:0] note_start_i,
  input  logic [TIME_BITS-1:0] blink_last_i,
  output logic                 ring_o,
  output logic                 latch_o,
  output logic                 led_o,
  output logic [NOTE_W-1:0]    pos_o,
  output logic [TIME_BITS-1:0] ring_start_o,
  output logic [TIME_BITS-1:0] note_start_o,
  output logic [TIME_BITS-1:0] blink_last_o,
  output result_t              res_o
);

  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [CMP_W-1:0]     now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] blink_el;
  logic [TIME_BITS-1:0] note_el;
  logic [TIME_BITS-1:0] ring_el;
  logic                 at_time;
  logic                 fire;
  logic                 redraw;
  logic [NOTE_W-1:0]    pos_cur;
  logic [TIME_BITS-1:0] note_start_cur;
  logic [TIME_BITS-1:0] ring_start_cur;

  assign now_ext = CMP_W'(item_i.now_ms);
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign at_time = (item_i.clock_hour == cfg_i.alarm_hour) &&
                   (item_i.clock_minute == cfg_i.alarm_minute);
  assign fire    = (item_i.kind == KIND_TICK) && cfg_i.alarm_enable && !ring_i &&
                   at_time && !latch_i;

  // on a fire the note and ring timers restart from now
  assign pos_cur        = fire ? '0 : pos_i;
  assign note_start_cur = fire ? now_t : note_start_i;
  assign ring_start_cur = fire ? now_t : ring_start_i;

  assign blink_el = now_t - blink_last_i;
  assign note_el  = now_t - note_start_cur;
  assign ring_el  = now_t - ring_start_cur;

  always_comb begin
    ring_o       = ring_i;
    latch_o      = latch_i;
    led_o        = led_i;
    pos_o        = pos_i;
    ring_start_o = ring_start_i;
    note_start_o = note_start_i;
    blink_last_o = blink_last_i;
    redraw       = 1'b0;
    if (item_i.kind == KIND_STOP) begin
      ring_o = 1'b0;
      led_o  = 1'b0;
      redraw = 1'b1;
    end else begin
      if (fire) begin
        ring_o       = 1'b1;
        latch_o      = 1'b1;
        pos_o        = '0;
        ring_start_o = now_t;
        note_start_o = now_t;
        redraw       = 1'b1;
      end
      if (!at_time) begin
        latch_o = 1'b0;
      end
      if (ring_i || fire) begin
        if (CMP_W'(blink_el) >= CMP_W'(cfg_i.blink_period_ms)) begin
          blink_last_o = now_t;
          led_o        = !led_i;
        end
        if (CMP_W'(note_el) >= CMP_W'(tune_ms(NOTE_NUM_W'(pos_cur)))) begin
          pos_o        = (pos_cur == NOTE_W'(MELODY_NOTES - 1)) ? '0 : pos_cur + 1'b1;
          note_start_o = now_t;
        end
        if (CMP_W'(ring_el) > CMP_W'(cfg_i.ring_timeout_ms)) begin
          ring_o = 1'b0;
          led_o  = 1'b0;
          redraw = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.ringing     = ring_o;
    res_o.led_lit     = led_o;
    res_o.tone_hz     = ring_o ? tune_hz(NOTE_NUM_W'(pos_o)) : '0;
    res_o.note_number = ring_o ? NOTE_NUM_W'(pos_o) : '0;
    res_o.just_fired  = fire;
    res_o.redraw      = redraw;
  end

endmodule

FILE: hw/rtl/alarm_match_melody_ringer.sv
`timescale 1ns / 1ps
// alarm ringer with blinking led and looping melody
// s_axis carries one transaction per service tick or stop request:
//   tuser is the kind (0 tick with current time, 1 stop), tdata the time.
// m_axis returns exactly one result transaction per input transaction.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i,
//   one register per cycle; the user must write only while no
//   transaction is in flight, which the block does not enforce.
// an accepted transaction lands in an input register; the single-pass
//   step logic then updates the ringer state and loads the result
//   register once the result register is empty or being taken.
// throughput is one transaction per cycle while m_axis_tready stays high,
//   set by the single state update between input and result registers.
// when the receiver stalls the result register holds, the input register
//   fills and then s_axis_tready drops until the result is taken.
// reset clears the ringer state and loads the register defaults
//   (alarm 07:00 disarmed, blink 500 ms, timeout 60000 ms).
module alarm_match_melody_ringer
  import amr_pkg::*;
#(
  parameter int unsigned MELODY_NOTES = 14,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // clock_hour[4:0], clock_minute[10:5], now_ms[42:11], zero fill
  input  logic [47:0]           s_axis_tdata,
  // kind[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // ringing[0], led_lit[1], tone_hz[11:2], note_number[17:12],
  // just_fired[18], redraw[19], zero fill
  output logic [23:0]           m_axis_tdata
);

  localparam int unsigned NOTE_W = (MELODY_NOTES > 1) ? $clog2(MELODY_NOTES) : 1;

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t out_res_q;
  result_t res_d;
  logic    out_valid_q;
  logic    advance;

  logic                 ring_q, ring_d;
  logic                 latch_q, latch_d;
  logic                 led_q, led_d;
  logic [NOTE_W-1:0]    pos_q, pos_d;
  logic [TIME_BITS-1:0] ring_start_q, ring_start_d;
  logic [TIME_BITS-1:0] note_start_q, note_start_d;
  logic [TIME_BITS-1:0] blink_last_q, blink_last_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  amr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  amr_step #(
    .MELODY_NOTES (MELODY_NOTES),
    .TIME_BITS    (TIME_BITS)
  ) u_step (
    .item_i       (in_item_q),
    .cfg_i        (cfg),
    .ring_i       (ring_q),
    .latch_i      (latch_q),
    .led_i        (led_q),
    .pos_i        (pos_q),
    .ring_start_i (ring_start_q),
    .note_start_i (note_start_q),
    .blink_last_i (blink_last_q),
    .ring_o       (ring_d),
    .latch_o      (latch_d),
    .led_o        (led_d),
    .pos_o        (pos_d),
    .ring_start_o (ring_start_d),
    .note_start_o (note_start_d),
    .blink_last_o (blink_last_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.kind         <= s_axis_tuser;
      in_item_q.clock_hour   <= s_axis_tdata[4:0];
      in_item_q.clock_minute <= s_axis_tdata[10:5];
      in_item_q.now_ms       <= s_axis_tdata[42:11];
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q       <= 1'b0;
      latch_q      <= 1'b0;
      led_q        <= 1'b0;
      pos_q        <= '0;
      ring_start_q <= '0;
      note_start_q <= '0;
      blink_last_q <= '0;
    end else if (advance) begin
      ring_q       <= ring_d;
      latch_q      <= latch_d;
      led_q        <= led_d;
      pos_q        <= pos_d;
      ring_start_q <= ring_start_d;
      note_start_q <= note_start_d;
      blink_last_q <= blink_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_res_q};

endmodule
